>>> rtl/ord_pkg.sv
`default_nettype none

package ord_pkg;

    typedef enum logic [1:0] {
        MODE_PUSH      = 2'd0,
        MODE_POP_FRONT = 2'd1,
        MODE_POP_BACK  = 2'd2,
        MODE_NOP       = 2'd3
    } mode_t;

    localparam int CAP_W     = 5;
    localparam int WORD_W    = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Per-transaction result flags handed from the ring control to the output stage
    typedef struct packed {
        logic take_data;
        logic status;
        logic overwrote;
        logic empty;
        logic full;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/ord_req_if.sv
`default_nettype none

interface ord_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink (input valid, input mode, input push_value, output ready);
endinterface

`default_nettype wire

>>> rtl/ord_rsp_if.sv
`default_nettype none

interface ord_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pop_data;
    logic               status;
    logic               overwrote_oldest;
    logic               is_empty;
    logic               is_full;

    modport source (output valid, output pop_data, output status, output overwrote_oldest,
                    output is_empty, output is_full, input ready);
    modport sink (input valid, input pop_data, input status, input overwrote_oldest,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

>>> rtl/ord_mem.sv
`default_nettype none

module ord_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic                         rd_en,
    input  wire logic [IDX_W-1:0]             addr,
    input  wire logic [ord_pkg::WORD_W-1:0]   wr_data,
    output logic      [ord_pkg::WORD_W-1:0]   rd_data
);
    import ord_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/ord_ctrl.sv
`default_nettype none

module ord_ctrl #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ord_pkg::CAP_W-1:0]   cfg_data,
    input  wire logic                        accept,
    input  wire logic [1:0]                  mode,
    output logic                             mem_wr_en,
    output logic                             mem_rd_en,
    output logic      [IDX_W-1:0]            mem_addr,
    output ord_pkg::result_t                 result
);
    import ord_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             full_reg, full_next;
    logic [31:0]      size;
    logic [IDX_W-1:0] head_inc, tail_inc, tail_dec;
    logic             empty_now;
    mode_t            op;

    // Capacity of zero acts as one, above DEPTH acts as DEPTH
    always_comb
    begin
        if (cap_reg == '0)
            size = 32'd1;
        else if (32'(cap_reg) > 32'(DEPTH))
            size = 32'(DEPTH);
        else
            size = 32'(cap_reg);
    end

    assign head_inc  = (32'(head_reg) + 32'd1 >= size) ? '0 : IDX_W'(32'(head_reg) + 32'd1);
    assign tail_inc  = (32'(tail_reg) + 32'd1 >= size) ? '0 : IDX_W'(32'(tail_reg) + 32'd1);
    assign tail_dec  = (tail_reg == '0) ? IDX_W'(size - 32'd1) : tail_reg - IDX_W'(1);
    assign empty_now = !full_reg && (head_reg == tail_reg);
    assign op        = mode_t'(mode);

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        full_next        = full_reg;
        mem_wr_en        = 1'b0;
        mem_rd_en        = 1'b0;
        mem_addr         = tail_reg;
        result.take_data = 1'b0;
        result.status    = 1'b0;
        result.overwrote = 1'b0;
        unique case (op)
            MODE_PUSH:
            begin
                mem_wr_en = accept;
                tail_next = tail_inc;
                if (full_reg)
                begin
                    result.overwrote = 1'b1;
                    head_next        = head_inc;
                end
                else if (head_reg == tail_inc)
                begin
                    full_next = 1'b1;
                end
            end
            MODE_POP_FRONT:
            begin
                mem_addr = head_reg;
                if (empty_now)
                begin
                    result.status = 1'b1;
                end
                else
                begin
                    mem_rd_en        = accept;
                    result.take_data = 1'b1;
                    head_next        = head_inc;
                    full_next        = 1'b0;
                end
            end
            MODE_POP_BACK:
            begin
                mem_addr = tail_dec;
                if (empty_now)
                begin
                    result.status = 1'b1;
                end
                else
                begin
                    mem_rd_en        = accept;
                    result.take_data = 1'b1;
                    tail_next        = tail_dec;
                    full_next        = 1'b0;
                end
            end
            MODE_NOP:
            begin
            end
            default:
            begin
            end
        endcase
        result.empty = !full_next && (head_next == tail_next);
        result.full  = full_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RESET;
            head_reg <= '0;
            tail_reg <= '0;
            full_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            cap_reg  <= cfg_data;
            head_reg <= '0;
            tail_reg <= '0;
            full_reg <= 1'b0;
        end
        else if (accept)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            full_reg <= full_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/overwriting_ring_deque.sv
// Overwriting ring deque of signed 32-bit words.
// req channel: one operation per transaction (mode: push at tail, pop front,
//   pop back, no-op; push_value is used by push only).
// rsp channel: exactly one result per operation, in order: pop_data,
//   status (pop on empty), overwrote_oldest, and the empty/full flags after
//   the operation.
// cfg_we/cfg_data write the capacity in use (0 acts as 1, above DEPTH as
//   DEPTH) and empty the buffer; write only while no result is pending.
// Latency: the result is presented the cycle after the request is taken.
// Throughput: one operation per cycle while results are taken; pointers update
//   at acceptance and the single-port word memory registers pop data
//   alongside the result, so back-to-back push/pop needs no forwarding.
// Stall: a single result register; req.ready drops while a result waits and
//   rsp.ready is low, and rises again in the cycle it is taken.
// Reset: capacity 16, buffer empty, no result pending. Memory contents are
//   not cleared; only written entries are ever read.
`default_nettype none

module overwriting_ring_deque #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [ord_pkg::CAP_W-1:0]  cfg_data,
    ord_req_if.sink                         req,
    ord_rsp_if.source                       rsp
);
    import ord_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              accept;
    logic              mem_wr_en, mem_rd_en;
    logic [IDX_W-1:0]  mem_addr;
    logic [WORD_W-1:0] rd_data;
    result_t           result;
    result_t           res_reg;
    logic              rsp_valid_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    ord_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .mode      (req.mode),
        .mem_wr_en (mem_wr_en),
        .mem_rd_en (mem_rd_en),
        .mem_addr  (mem_addr),
        .result    (result)
    );

    ord_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (req.push_value),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            rsp_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= result;
        end
    end

    // Read data lands in the memory's output register alongside res_reg
    assign rsp.valid            = rsp_valid_reg;
    assign rsp.pop_data         = res_reg.take_data ? rd_data : '0;
    assign rsp.status           = res_reg.status;
    assign rsp.overwrote_oldest = res_reg.overwrote;
    assign rsp.is_empty         = res_reg.empty;
    assign rsp.is_full          = res_reg.full;

endmodule

`default_nettype wire

>>> rtl/ord_checker.sv
`default_nettype none

module ord_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] pop_data,
    input wire logic        status,
    input wire logic        overwrote_oldest,
    input wire logic        is_empty,
    input wire logic        is_full
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(pop_data) && $stable(status))
        else $error("result changed while stalled");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted operation produced no result");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(is_empty && is_full))
        else $error("buffer reported empty and full at once");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> pop_data == 32'd0 && !overwrote_oldest && is_empty)
        else $error("empty pop result carries data or wrong flags");

    a_overwrite_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && overwrote_oldest |-> is_full && !status && pop_data == 32'd0)
        else $error("overwrite reported on a buffer that is not full");

endmodule

bind overwriting_ring_deque ord_checker u_ord_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .pop_data         (rsp.pop_data),
    .status           (rsp.status),
    .overwrote_oldest (rsp.overwrote_oldest),
    .is_empty         (rsp.is_empty),
    .is_full          (rsp.is_full)
);

`default_nettype wire
